[rtl/core/pbs_pkg.sv]
package pbs_pkg;

	// Configuration register indexes and the address width of the register port.
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned REG_IDX_W = 1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_BURST_INTERVAL    = 1'b0,
		REG_PACKETS_PER_BURST = 1'b1
	} reg_idx_t;

	// Register widths and reset values.
	localparam int unsigned INTERVAL_W = 32;
	localparam int unsigned PPB_W      = 8;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 32'd100000;
	localparam logic [PPB_W-1:0]      PPB_RST      = 8'd1;

	// Field widths.
	localparam int unsigned TIME_W  = 64;
	localparam int unsigned SEQ_W   = 16;
	localparam int unsigned BURST_W = 32;
	localparam int unsigned TOTAL_W = 64;

	// One result item as it sits in the output register.
	typedef struct packed {
		logic                  send;
		logic [SEQ_W-1:0]      packet_seq;
		logic [TIME_W-1:0]     send_time;
		logic [BURST_W-1:0]    burst_number;
		logic [PPB_W-1:0]      position_in_burst;
		logic [TOTAL_W-1:0]    bursts_started;
		logic [TOTAL_W-1:0]    packets_sent;
	} result_t;

endpackage

[rtl/core/probe_burst_scheduler.sv]
// A tick transfer is registered in the tick register, and its result is then registered in the
// result register, where it is offered. Throughput: one tick per cycle while the output is not
// stalled; the single 64-bit deadline add and compare sets the path.
// Reset (arst_n low, asynchronous): no tick or result held, scheduler state cleared with
// the first burst pending, burst_interval back to 100000 and packets_per_burst back to 1.
module probe_burst_scheduler (
	input  logic                          clk,
	input  logic                          arst_n,
	// Register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pbs_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// Tick channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [pbs_pkg::TIME_W-1:0]    time_now,
	// Result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          send,
	output logic [pbs_pkg::SEQ_W-1:0]     packet_seq,
	output logic [pbs_pkg::TIME_W-1:0]    send_time,
	output logic [pbs_pkg::BURST_W-1:0]   burst_number,
	output logic [pbs_pkg::PPB_W-1:0]     position_in_burst,
	output logic [pbs_pkg::TOTAL_W-1:0]   bursts_started,
	output logic [pbs_pkg::TOTAL_W-1:0]   packets_sent
);
	import pbs_pkg::*;

	// Configuration registers.
	logic [INTERVAL_W-1:0] burst_interval_q;
	logic [PPB_W-1:0]      packets_per_burst_q;

	// Scheduler state.
	logic                  first_pending_q;
	logic [PPB_W-1:0]      packets_left_q;
	logic [SEQ_W-1:0]      next_seq_q;
	logic [BURST_W-1:0]    current_burst_q;
	logic [TIME_W-1:0]     burst_start_time_q;
	logic [TOTAL_W-1:0]    burst_total_q;
	logic [TOTAL_W-1:0]    packet_total_q;

	// Pipeline registers.
	logic                  valid_s1;
	logic [TIME_W-1:0]     time_s1;
	logic                  valid_s2;
	result_t               res_s2;

	logic                  cfg_write;
	reg_idx_t              cfg_idx;
	logic                  adv_s1;
	logic                  in_take;
	logic [TIME_W-1:0]     deadline;
	logic                  in_burst;
	logic                  start_burst;
	logic                  fire;
	result_t               res_d;

	// Register port: always ready, a write lands in the access phase.
	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite;
	assign cfg_idx   = reg_idx_t'(paddr[PADDR_W-1 -: REG_IDX_W]);

	always_comb begin
		unique case (cfg_idx)
			REG_BURST_INTERVAL:    prdata = burst_interval_q;
			REG_PACKETS_PER_BURST: prdata = {{(32-PPB_W){1'b0}}, packets_per_burst_q};
			default:               prdata = '0;
		endcase
	end

	// A write that is zero in the register's bits leaves the register unchanged.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_interval_q    <= INTERVAL_RST;
			packets_per_burst_q <= PPB_RST;
		end else if (cfg_write) begin
			unique case (cfg_idx)
				REG_BURST_INTERVAL: begin
					if (pwdata != '0)
						burst_interval_q <= pwdata;
				end
				REG_PACKETS_PER_BURST: begin
					if (pwdata[PPB_W-1:0] != '0)
						packets_per_burst_q <= pwdata[PPB_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// Handshake: the held tick moves on when the result register is free or draining.
	assign adv_s1    = !valid_s2 || !out_stall;
	assign in_stall  = valid_s1 && !adv_s1;
	assign in_take   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take)
			time_s1 <= time_now;
	end

	// Decision: continue a running burst, or start one at the first tick or the deadline.
	assign deadline    = burst_start_time_q + {{(TIME_W-INTERVAL_W){1'b0}}, burst_interval_q};
	assign in_burst    = packets_left_q != '0;
	assign start_burst = !in_burst && (first_pending_q || time_s1 >= deadline);
	assign fire        = in_burst || start_burst;

	always_comb begin
		res_d = '0;
		if (fire) begin
			res_d.send         = 1'b1;
			res_d.packet_seq   = next_seq_q;
			res_d.send_time    = time_s1;
			res_d.burst_number = start_burst ? current_burst_q + 1'b1 : current_burst_q;
			res_d.position_in_burst = in_burst ? packets_per_burst_q - packets_left_q : '0;
			res_d.packets_sent = packet_total_q + 1'b1;
		end else begin
			res_d.packets_sent = packet_total_q;
		end
		res_d.bursts_started = start_burst ? burst_total_q + 1'b1 : burst_total_q;
	end

	// State update, once for each tick that moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_pending_q    <= 1'b1;
			packets_left_q     <= '0;
			next_seq_q         <= '0;
			current_burst_q    <= '0;
			burst_start_time_q <= '0;
			burst_total_q      <= '0;
			packet_total_q     <= '0;
		end else if (valid_s1 && adv_s1) begin
			if (in_burst) begin
				packets_left_q <= packets_left_q - 1'b1;
			end else if (start_burst) begin
				first_pending_q    <= 1'b0;
				current_burst_q    <= res_d.burst_number;
				packets_left_q     <= packets_per_burst_q - 1'b1;
				burst_start_time_q <= time_s1;
				burst_total_q      <= res_d.bursts_started;
			end
			if (fire) begin
				next_seq_q     <= next_seq_q + 1'b1;
				packet_total_q <= res_d.packets_sent;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1)
			res_s2 <= res_d;
	end

	assign out_valid         = valid_s2;
	assign send              = res_s2.send;
	assign packet_seq        = res_s2.packet_seq;
	assign send_time         = res_s2.send_time;
	assign burst_number      = res_s2.burst_number;
	assign position_in_burst = res_s2.position_in_burst;
	assign bursts_started    = res_s2.bursts_started;
	assign packets_sent      = res_s2.packets_sent;

endmodule

[dv/probe_burst_scheduler_test.sv]
module probe_burst_scheduler_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pbs_pkg::*;

	// The receiver holds off for a long stretch once this many transfers have been taken.
	localparam int HOLD_AT     = 500;
	localparam int HOLD_CYCLES = 200;
	localparam int PHASE_TICKS = 200;
	localparam int NUM_PHASES  = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [PADDR_W-1:0]    paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [TIME_W-1:0]     time_now = '0;

	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  send;
	logic [SEQ_W-1:0]      packet_seq;
	logic [TIME_W-1:0]     send_time;
	logic [BURST_W-1:0]    burst_number;
	logic [PPB_W-1:0]      position_in_burst;
	logic [TOTAL_W-1:0]    bursts_started;
	logic [TOTAL_W-1:0]    packets_sent;

	// Ticks waiting to be offered, and the results the scheduler should give back.
	logic [TIME_W-1:0] tick_queue[$];
	result_t           expected_results[$];

	int idle_pct = 21;
	int stall_pct = 21;
	int errors = 0;

	// Register copies and scheduler state kept by the predictor.
	logic [INTERVAL_W-1:0] cfg_interval = INTERVAL_RST;
	logic [PPB_W-1:0]      cfg_ppb = PPB_RST;
	logic                  first_burst_due = 1'b1;
	logic [PPB_W-1:0]      left_in_burst = '0;
	logic [SEQ_W-1:0]      seq_counter = '0;
	logic [BURST_W-1:0]    burst_num = '0;
	logic [TIME_W-1:0]     last_burst_start = '0;
	logic [TOTAL_W-1:0]    bursts_total = '0;
	logic [TOTAL_W-1:0]    packets_total = '0;

	probe_burst_scheduler u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.time_now          (time_now),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.send              (send),
		.packet_seq        (packet_seq),
		.send_time         (send_time),
		.burst_number      (burst_number),
		.position_in_burst (position_in_burst),
		.bursts_started    (bursts_started),
		.packets_sent      (packets_sent)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Works out the result of one accepted tick and updates the scheduler state.
	task automatic schedule_tick(input logic [TIME_W-1:0] now);
		result_t           r;
		logic              fire;
		logic [PPB_W-1:0]  pos;
		logic [TIME_W-1:0] deadline;
		r = '0;
		fire = 1'b0;
		pos = '0;
		deadline = last_burst_start + TIME_W'(cfg_interval);
		if (left_in_burst != '0) begin
			// Mid-burst: the tick sends whatever the time says.
			pos = cfg_ppb - left_in_burst;
			left_in_burst = left_in_burst - 1'b1;
			fire = 1'b1;
		end else if (first_burst_due || now >= deadline) begin
			first_burst_due = 1'b0;
			burst_num = burst_num + 1'b1;
			left_in_burst = cfg_ppb - 1'b1;
			last_burst_start = now;
			bursts_total = bursts_total + 1'b1;
			fire = 1'b1;
		end
		if (fire) begin
			r.send = 1'b1;
			r.packet_seq = seq_counter;
			r.send_time = now;
			r.burst_number = burst_num;
			r.position_in_burst = pos;
			seq_counter = seq_counter + 1'b1;
			packets_total = packets_total + 1'b1;
		end
		r.bursts_started = bursts_total;
		r.packets_sent = packets_total;
		expected_results.push_back(r);
	endtask

	// Writes one register over the APB port and mirrors the write in the predictor.
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * idx);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// Zero values are ignored once masked to the register width.
		if (idx == REG_BURST_INTERVAL) begin
			if (value[INTERVAL_W-1:0] != '0)
				cfg_interval = value[INTERVAL_W-1:0];
		end else if (idx == REG_PACKETS_PER_BURST) begin
			if (value[PPB_W-1:0] != '0)
				cfg_ppb = value[PPB_W-1:0];
		end
	endtask

	// Waits until every tick has been taken and every result has come back.
	task automatic wait_drained();
		do @(negedge clk); while (tick_queue.size() != 0 || in_valid ||
			expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// Tick driver: offers the next queued tick, holding it while the scheduler stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			time_now <= '0;
		end else begin
			if (in_valid && !in_stall)
				schedule_tick(time_now);
			if (!in_valid || !in_stall) begin
				if (tick_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					in_valid <= 1'b1;
					time_now <= tick_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each transfer against the oldest expectation and drives stall.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		result_t exp_r;
		int      taken;
		int      hold_left;
		if (!arst_n) begin
			out_stall <= 1'b0;
			taken = 0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result transfer with none expected: send %0b seq 0x%0h",
						$time, send, packet_seq);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					check_field("send", 64'(exp_r.send), 64'(send));
					check_field("packet_seq", 64'(exp_r.packet_seq), 64'(packet_seq));
					check_field("send_time", exp_r.send_time, send_time);
					check_field("burst_number", 64'(exp_r.burst_number), 64'(burst_number));
					check_field("position_in_burst", 64'(exp_r.position_in_burst),
						64'(position_in_burst));
					check_field("bursts_started", exp_r.bursts_started, bursts_started);
					check_field("packets_sent", exp_r.packets_sent, packets_sent);
				end
				taken++;
				if (taken == HOLD_AT)
					hold_left = HOLD_CYCLES;
			end
			// A long hold-off lets the scheduler fill up and stall its input.
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// Stimulus: directed ticks first, then random phases under changing settings.
	initial begin : stimulus
		logic [TIME_W-1:0]     clock_us;
		logic [INTERVAL_W-1:0] new_interval;
		logic [PPB_W-1:0]      new_ppb;
		int                    roll;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// First tick fires near the top of time; the deadline then wraps past zero.
		tick_queue.push_back(64'hFFFF_FFFF_FFFF_FFF0);
		tick_queue.push_back(64'd5);
		tick_queue.push_back(64'd99983);
		tick_queue.push_back(64'd99984);
		tick_queue.push_back(64'd0);
		wait_drained();

		// Zero writes, and a packet count whose low byte is zero, are ignored.
		write_reg(REG_BURST_INTERVAL, 32'd0);
		write_reg(REG_PACKETS_PER_BURST, 32'h1234_5600);
		write_reg(REG_PACKETS_PER_BURST, 32'd3);
		write_reg(REG_BURST_INTERVAL, 32'd1);
		tick_queue.push_back(64'd99984);
		tick_queue.push_back(64'd99985);
		tick_queue.push_back(64'd0);
		wait_drained();

		// Burst size raised mid-burst, then lowered so the position wraps.
		write_reg(REG_PACKETS_PER_BURST, 32'hABCD_EF05);
		tick_queue.push_back(64'd0);
		tick_queue.push_back(64'd99986);
		wait_drained();
		write_reg(REG_PACKETS_PER_BURST, 32'd1);
		repeat (4) tick_queue.push_back(64'd0);
		wait_drained();

		// Largest settings; the all-ones time meets any deadline.
		write_reg(REG_BURST_INTERVAL, 32'hFFFF_FFFF);
		write_reg(REG_PACKETS_PER_BURST, 32'd255);
		tick_queue.push_back(64'hFFFF_FFFF_FFFF_FFFF);
		wait_drained();

		clock_us = '1;
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			// One phase runs with no idling on either side.
			idle_pct = (phase == 2) ? 0 : 21;
			stall_pct = (phase == 2) ? 0 : 21;
			case (phase)
				0: begin
					new_interval = 32'hFFFF_FFFF;
					new_ppb = 8'd255;
				end
				1: begin
					new_interval = 32'd1;
					new_ppb = 8'd1;
				end
				2: begin
					new_interval = 32'd1;
					new_ppb = 8'd255;
				end
				3: begin
					new_interval = 32'hFFFF_FFFF;
					new_ppb = 8'd1;
				end
				default: begin
					new_interval = ($urandom_range(0, 3) == 0) ? $urandom :
						$urandom_range(1, 5000);
					new_ppb = PPB_W'($urandom_range(1, 16));
				end
			endcase
			if ($urandom_range(0, 3) == 0)
				write_reg(reg_idx_t'($urandom_range(0, 1)), 32'd0);
			write_reg(REG_BURST_INTERVAL, new_interval);
			write_reg(REG_PACKETS_PER_BURST, 32'(new_ppb));

			// Mostly a clock running forward, with some jumps anywhere in the range.
			for (int n = 0; n < PHASE_TICKS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 85)
					clock_us = clock_us + $urandom_range(0, cfg_interval / 2 + 1);
				else if (roll < 92)
					clock_us = {$urandom, $urandom};
				else if (roll < 96)
					clock_us = '1;
				else
					clock_us = '0;
				tick_queue.push_back(clock_us);
			end
			wait_drained();
		end

		repeat (10) @(negedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("probe_burst_scheduler test passed");
		else
			$display("probe_burst_scheduler test failed");
		$finish;
	end

	// Ends a run that hangs.
	initial begin
		#2_000_000;
		$display("probe_burst_scheduler test failed");
		$finish;
	end

endmodule
